/* sv/olir_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered list insert/remove: shared package
// Types, widths and defaults used by the list block and its storage.
// ----------------------------------------------------------------------------
package olir_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int POS_W    = 5;
  localparam int BASE_W   = 8;
  localparam int HEIGHT_W = 8;
  localparam int ENTRY_W  = BASE_W + HEIGHT_W;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_CMP,
    S_SHF_RD,
    S_SHF_WR,
    S_FIN
  } state_e;

endpackage

/* sv/olir_ram.sv */
// ----------------------------------------------------------------------------
// Ordered list insert/remove: generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module olir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ordered_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// Ordered list insert/remove: top level
// Operation: an insert at p moves each entry from p up one slot (a read state
// and a write state each), then writes the new entry; a remove scans for the key
// and shifts later entries down; a refused insert goes straight to the result.
// One item at a time: no new item is taken until the result is in the output.
// Reset: the length, state and output valid clear asynchronously; entries hold.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove #(
  parameter int CAPACITY = olir_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // position[4:0], key_base[12:5], entry_height[20:13]
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // status[1:0], list_length[6:2]
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > olir_pkg::POS_W) ? CW : olir_pkg::POS_W;
  localparam int LW = (CW > olir_pkg::LEN_W) ? CW : olir_pkg::LEN_W;

  olir_pkg::state_e  state_q, state_d;
  olir_pkg::status_e st_q, st_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [olir_pkg::BASE_W-1:0]   key_q, key_d;
  logic [olir_pkg::HEIGHT_W-1:0] hgt_q, hgt_d;
  logic       m_valid_q, m_valid_d;
  logic [7:0] m_data_q, m_data_d;

  logic [olir_pkg::POS_W-1:0]    pos_in;
  logic [olir_pkg::BASE_W-1:0]   key_in;
  logic [olir_pkg::HEIGHT_W-1:0] hgt_in;
  logic [PW-1:0] pos_ext, cnt_ext;
  logic [LW-1:0] len_ext;
  logic accept, ins_bad, is_remove, out_free, rem_hit, idx_end;
  logic [CW-1:0] idx_inc, idx_dec;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [olir_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  assign pos_in    = s_axis_tdata[4:0];
  assign key_in    = s_axis_tdata[12:5];
  assign hgt_in    = s_axis_tdata[20:13];
  assign pos_ext   = PW'(pos_in);
  assign cnt_ext   = PW'(count_q);
  assign len_ext   = LW'(count_q);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_remove = (s_axis_tuser == olir_pkg::MODE_REMOVE);
  assign ins_bad   = (pos_ext > cnt_ext) || (count_q == CW'(CAPACITY));
  assign out_free  = !m_valid_q || m_axis_tready;
  assign idx_inc   = idx_q + CW'(1);
  assign idx_dec   = idx_q - CW'(1);
  assign rem_hit   = (ram_rdata[olir_pkg::BASE_W-1:0] == key_q);
  assign idx_end   = !(idx_inc < count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      olir_pkg::S_IDLE: begin
        if (accept) begin
          if (is_remove) begin
            state_d = (count_q == '0) ? olir_pkg::S_FIN : olir_pkg::S_REM_RD;
          end else if (ins_bad) begin
            state_d = olir_pkg::S_FIN;
          end else begin
            state_d = (cnt_ext > pos_ext) ? olir_pkg::S_INS_RD : olir_pkg::S_INS_PUT;
          end
        end
      end
      olir_pkg::S_INS_RD:  state_d = olir_pkg::S_INS_WR;
      olir_pkg::S_INS_WR: begin
        state_d = (idx_dec > pos_q) ? olir_pkg::S_INS_RD : olir_pkg::S_INS_PUT;
      end
      olir_pkg::S_INS_PUT: state_d = olir_pkg::S_FIN;
      olir_pkg::S_REM_RD:  state_d = olir_pkg::S_REM_CMP;
      olir_pkg::S_REM_CMP: begin
        if (rem_hit) begin
          state_d = idx_end ? olir_pkg::S_FIN : olir_pkg::S_SHF_RD;
        end else begin
          state_d = idx_end ? olir_pkg::S_FIN : olir_pkg::S_REM_RD;
        end
      end
      olir_pkg::S_SHF_RD:  state_d = olir_pkg::S_SHF_WR;
      olir_pkg::S_SHF_WR:  state_d = idx_end ? olir_pkg::S_FIN : olir_pkg::S_SHF_RD;
      olir_pkg::S_FIN:     state_d = out_free ? olir_pkg::S_IDLE : olir_pkg::S_FIN;
      default:             state_d = olir_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    st_d      = st_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    key_d     = key_q;
    hgt_d     = hgt_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[AW-1:0];
    unique case (state_q)
      olir_pkg::S_IDLE: begin
        if (accept) begin
          key_d = key_in;
          hgt_d = hgt_in;
          pos_d = pos_ext[CW-1:0];
          if (is_remove) begin
            idx_d = '0;
            st_d  = olir_pkg::ST_NOT_FOUND;
          end else begin
            idx_d = count_q;
            st_d  = ins_bad ? olir_pkg::ST_REFUSED : olir_pkg::ST_DONE;
          end
        end
      end
      olir_pkg::S_INS_RD: begin
        ram_raddr = idx_dec[AW-1:0];
      end
      olir_pkg::S_INS_WR: begin
        ram_we = 1'b1;
        idx_d  = idx_dec;
      end
      olir_pkg::S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = {hgt_q, key_q};
        count_d   = count_q + CW'(1);
      end
      olir_pkg::S_REM_RD: begin
      end
      olir_pkg::S_REM_CMP: begin
        if (rem_hit) begin
          st_d    = olir_pkg::ST_DONE;
          count_d = count_q - CW'(1);
        end else begin
          idx_d = idx_inc;
        end
      end
      olir_pkg::S_SHF_RD: begin
        ram_raddr = idx_inc[AW-1:0];
      end
      olir_pkg::S_SHF_WR: begin
        ram_we = 1'b1;
        idx_d  = idx_inc;
      end
      olir_pkg::S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, len_ext[olir_pkg::LEN_W-1:0], st_q};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= olir_pkg::S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q     <= st_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    key_q    <= key_d;
    hgt_q    <= hgt_d;
    m_data_q <= m_data_d;
  end

  olir_ram #(
    .WIDTH(olir_pkg::ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == olir_pkg::S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("block ready again right after taking an item");

  a_write_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != olir_pkg::S_IDLE && state_q != olir_pkg::S_FIN))
    else $error("entry store written outside an operation");

  a_count_steady_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olir_pkg::S_IDLE) |=> (count_q == $past(count_q)))
    else $error("list length changed while idle");

endmodule
